[rtl/opse_pkg.sv]
// Shared types and widths for the orthogonal polynomial series evaluator.
package opse_pkg;

  localparam int MAX_TERMS_DEF = 256;

  // Shared multiplier operand and result widths.
  localparam int A_W     = 48;
  localparam int B_W     = 34;
  localparam int CHUNK_W = B_W / 2;
  localparam int PROD_W  = A_W + B_W;
  localparam int Q_W     = 47;
  localparam int RES_W   = 48;

  // Reciprocal width and default divisor width.
  localparam int RECIP_W = 32;
  localparam int LW_DEF  = $clog2(2 * MAX_TERMS_DEF);

  // Rounding right shift applied after a product.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_29,
    SH_30,
    SH_32
  } shift_t;

  typedef struct packed {
    logic                    start;
    shift_t                  shift;
    logic signed [A_W-1:0]   a;
    logic signed [B_W-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic                    busy;
    logic signed [RES_W-1:0] res;
  } mul_rsp_t;

endpackage

[rtl/orthogonal_poly_series_eval.sv]
// Top level of the Chebyshev / Legendre series evaluator with its sequencer.
//
// Usage: coefficients arrive one request at a time on the in_ channel
// (in_valid / in_stall). A request with in_first set latches in_point (x, Q1.30)
// and in_basis and starts a new series; in_last closes it and produces one
// request on the out_ channel carrying out_sum (scale 2^-24, clipped to 48 bits)
// and out_saturated. Other requests produce no output.
// Rate: one request at a time; in_stall is high while a coefficient is in work.
// Each product goes through one shared multiplier; a Legendre recurrence
// step also waits on a reciprocal divider that runs alongside its first
// three products. A term with no recurrence step needs only the term
// product; a Chebyshev step adds one product and a Legendre step four, and
// the even/odd forms run two recurrence steps per coefficient.
// Output: out_valid is set in the finish state once the last term is added.
// Reset (rst_n low, synchronous) clears the series state: x = 0, basis 0,
// both recurrence values and the sum zero. No clearing pass is needed.
// Stall: a result waits in the output register while out_stall is high; the
// next coefficients are still taken; a last one is worked through, but the
// block then holds in its finish state until the waiting result is taken.
module orthogonal_poly_series_eval #(
  parameter int MAX_TERMS = opse_pkg::MAX_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_coefficient,
  input  logic signed [31:0] in_point,
  input  logic [2:0]         in_basis,
  input  logic               in_first,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_sum,
  output logic               out_saturated
);

  localparam int DW = $clog2(MAX_TERMS + 1);   // item counter, holds MAX_TERMS
  localparam int LW = $clog2(2 * MAX_TERMS);   // recurrence degree l

  localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;

  localparam logic [2:0] BASIS_CHEB      = 3'd0;
  localparam logic [2:0] BASIS_CHEB_EVEN = 3'd1;
  localparam logic [2:0] BASIS_CHEB_ODD  = 3'd2;
  localparam logic [2:0] BASIS_LEG       = 3'd3;
  localparam logic [2:0] BASIS_LEG_EVEN  = 3'd4;
  localparam logic [2:0] BASIS_LEG_ODD   = 3'd5;

  typedef enum logic [1:0] {
    FORM_FULL,
    FORM_EVEN,
    FORM_ODD,
    FORM_NONE
  } form_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ADV,
    S_WAIT_A,
    S_WAIT_N1,
    S_WAIT_N2,
    S_WAIT_DIV,
    S_WAIT_R,
    S_UPD,
    S_TERM,
    S_WAIT_T,
    S_FINISH
  } state_t;

  state_t                    state_r;

  // series state
  logic signed [33:0]        pp_r;       // latest polynomial value
  logic signed [33:0]        pp2_r;      // the one before
  logic signed [47:0]        acc_r;
  logic [DW-1:0]             deg_r;
  logic signed [31:0]        point_r;
  logic [2:0]                basis_r;
  logic                      ovf_r;

  // per-item work registers
  logic signed [31:0]        coef_r;
  logic                      last_r;
  logic signed [33:0]        p_r;        // polynomial used for this term
  logic signed [33:0]        newp_r;
  logic signed [47:0]        m1_r;
  logic signed [47:0]        n_r;
  logic [LW-1:0]             step_l_r;
  logic                      two_r;
  logic                      second_r;
  logic                      cap_second_r;

  logic                      out_valid_r;
  logic signed [47:0]        out_sum_r;
  logic                      out_sat_r;

  opse_pkg::mul_req_t        mul_req_r;
  opse_pkg::mul_rsp_t        mul_rsp;
  logic                      div_start_r;
  logic                      div_done;
  logic [opse_pkg::RECIP_W-1:0] recip;

  form_t                     form;
  logic                      leg;
  logic                      active;
  logic [LW:0]               two_l_m1;
  logic [LW-1:0]             l_m1;
  logic signed [47:0]        cheb_diff;
  logic signed [48:0]        acc_sum;
  logic                      acc_ovf;
  logic signed [47:0]        acc_sat;

  function automatic logic signed [33:0] sat_poly(input logic signed [47:0] v);
    logic signed [33:0] r;
    if (v[47:33] == {15{v[47]}}) begin
      r = v[33:0];
    end else if (v[47]) begin
      r = {1'b1, 33'd0};
    end else begin
      r = {1'b0, {33{1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    case (basis_r)
      BASIS_CHEB, BASIS_LEG:           form = FORM_FULL;
      BASIS_CHEB_EVEN, BASIS_LEG_EVEN: form = FORM_EVEN;
      BASIS_CHEB_ODD, BASIS_LEG_ODD:   form = FORM_ODD;
      default:                         form = FORM_NONE;
    endcase
  end

  assign leg    = (basis_r >= BASIS_LEG);
  assign active = (deg_r < DW'(MAX_TERMS)) && (form != FORM_NONE);

  assign two_l_m1  = {step_l_r, 1'b0} - (LW + 1)'(1);
  assign l_m1      = step_l_r - LW'(1);
  assign cheb_diff = mul_rsp.res - 48'(pp2_r);

  assign acc_sum = {acc_r[47], acc_r} + {mul_rsp.res[47], mul_rsp.res};
  assign acc_ovf = (acc_sum[48] != acc_sum[47]);
  assign acc_sat = acc_ovf ? (acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                           : acc_sum[47:0];

  opse_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req_r),
    .rsp   (mul_rsp)
  );

  opse_recip #(
    .LW (LW)
  ) u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .l     (step_l_r),
    .done  (div_done),
    .recip (recip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pp_r         <= '0;
      pp2_r        <= '0;
      acc_r        <= '0;
      deg_r        <= '0;
      point_r      <= '0;
      basis_r      <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      out_sum_r    <= '0;
      out_sat_r    <= 1'b0;
      mul_req_r    <= '0;
      div_start_r  <= 1'b0;
      coef_r       <= '0;
      last_r       <= 1'b0;
      p_r          <= '0;
      newp_r       <= '0;
      m1_r         <= '0;
      n_r          <= '0;
      step_l_r     <= '0;
      two_r        <= 1'b0;
      second_r     <= 1'b0;
      cap_second_r <= 1'b0;
    end else begin
      mul_req_r.start <= 1'b0;
      div_start_r     <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            coef_r <= in_coefficient;
            last_r <= in_last;
            if (in_first) begin
              point_r <= in_point;
              basis_r <= in_basis;
              acc_r   <= '0;
              ovf_r   <= 1'b0;
              deg_r   <= '0;
              pp2_r   <= ONE_Q30;
              pp_r    <= 34'(in_point);
            end
            state_r <= S_DECIDE;
          end
        end

        // Pick the polynomial: constant, x, one/two recurrence steps, or no term.
        S_DECIDE: begin
          second_r     <= 1'b0;
          two_r        <= (form != FORM_FULL);
          cap_second_r <= (form == FORM_ODD);
          if (!active) begin
            state_r <= S_FINISH;
          end else if (form == FORM_FULL) begin
            if (deg_r == '0) begin
              p_r     <= ONE_Q30;
              state_r <= S_TERM;
            end else if (deg_r == DW'(1)) begin
              p_r     <= 34'(point_r);
              state_r <= S_TERM;
            end else begin
              step_l_r <= LW'(deg_r);
              state_r  <= S_ADV;
            end
          end else if (deg_r == '0) begin
            p_r     <= (form == FORM_EVEN) ? ONE_Q30 : 34'(point_r);
            state_r <= S_TERM;
          end else begin
            step_l_r <= LW'({deg_r, 1'b0});
            state_r  <= S_ADV;
          end
        end

        S_ADV: begin
          mul_req_r <= '{start: 1'b1,
                         shift: (leg ? opse_pkg::SH_30 : opse_pkg::SH_29),
                         a: 48'(point_r),
                         b: pp_r};
          if (leg) begin
            div_start_r <= 1'b1;
          end
          state_r <= S_WAIT_A;
        end

        S_WAIT_A: begin
          if (mul_rsp.done) begin
            if (leg) begin
              mul_req_r <= '{start: 1'b1, shift: opse_pkg::SH_NONE,
                             a: mul_rsp.res, b: 34'(two_l_m1)};
              state_r   <= S_WAIT_N1;
            end else begin
              newp_r  <= sat_poly(cheb_diff);
              state_r <= S_UPD;
            end
          end
        end

        S_WAIT_N1: begin
          if (mul_rsp.done) begin
            m1_r      <= mul_rsp.res;
            mul_req_r <= '{start: 1'b1, shift: opse_pkg::SH_NONE,
                           a: 48'(pp2_r), b: 34'(l_m1)};
            state_r   <= S_WAIT_N2;
          end
        end

        S_WAIT_N2: begin
          if (mul_rsp.done) begin
            n_r     <= m1_r - mul_rsp.res;
            state_r <= S_WAIT_DIV;
          end
        end

        S_WAIT_DIV: begin
          if (div_done) begin
            mul_req_r <= '{start: 1'b1, shift: opse_pkg::SH_32,
                           a: n_r, b: 34'(recip)};
            state_r   <= S_WAIT_R;
          end
        end

        S_WAIT_R: begin
          if (mul_rsp.done) begin
            newp_r  <= sat_poly(mul_rsp.res);
            state_r <= S_UPD;
          end
        end

        // Shift the recurrence; odd form keeps the second step's value.
        S_UPD: begin
          pp2_r <= pp_r;
          pp_r  <= newp_r;
          if (second_r == cap_second_r) begin
            p_r <= newp_r;
          end
          if (two_r && !second_r) begin
            second_r <= 1'b1;
            step_l_r <= step_l_r + LW'(1);
            state_r  <= S_ADV;
          end else begin
            state_r <= S_TERM;
          end
        end

        S_TERM: begin
          mul_req_r <= '{start: 1'b1, shift: opse_pkg::SH_30,
                         a: 48'(coef_r), b: p_r};
          state_r   <= S_WAIT_T;
        end

        S_WAIT_T: begin
          if (mul_rsp.done) begin
            acc_r <= acc_sat;
            if (acc_ovf) begin
              ovf_r <= 1'b1;
            end
            state_r <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!last_r) begin
            if (deg_r < DW'(MAX_TERMS)) begin
              deg_r <= deg_r + DW'(1);
            end
            state_r <= S_IDLE;
          end else if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_sum_r   <= acc_r;
            out_sat_r   <= ovf_r;
            acc_r       <= '0;
            ovf_r       <= 1'b0;
            deg_r       <= '0;
            pp2_r       <= ONE_Q30;
            pp_r        <= 34'(point_r);
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_sum       = out_sum_r;
  assign out_saturated = out_sat_r;

  // The multiplier never gets a new product while one is in flight.
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req_r.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // The reciprocal product only issues once the divider has finished.
  a_recip_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_req_r.start && (mul_req_r.shift == opse_pkg::SH_32)) |-> div_done)
    else $error("reciprocal used before divider finished");

  // A waiting result is never overwritten by the next series.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && last_r && out_valid_r && out_stall)
      |=> (state_r == S_FINISH && out_valid_r))
    else $error("pending result lost");

  // The item counter stops at the term limit.
  a_deg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    deg_r <= DW'(MAX_TERMS))
    else $error("degree counter beyond term limit");

endmodule

[rtl/opse_mul.sv]
// Shared sign-magnitude multiplier: two partial products, round half away, sign.
module opse_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  opse_pkg::mul_req_t req,
  output opse_pkg::mul_rsp_t rsp
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_LO,
    M_HI,
    M_RND,
    M_SGN
  } mstate_t;

  mstate_t                             state_r;
  logic                                done_r;
  logic signed [opse_pkg::RES_W-1:0]   res_r;

  logic [opse_pkg::A_W-1:0]            mag_a_r;
  logic [opse_pkg::B_W-1:0]            mag_b_r;
  logic                                neg_r;
  opse_pkg::shift_t                    shift_r;
  logic [opse_pkg::PROD_W-1:0]         prod_r;
  logic [opse_pkg::Q_W-1:0]            q_r;

  logic [opse_pkg::A_W-1:0]            a_mag;
  logic [opse_pkg::B_W-1:0]            b_mag;
  logic [opse_pkg::CHUNK_W-1:0]        chunk;
  logic [opse_pkg::A_W+opse_pkg::CHUNK_W-1:0] pp;
  logic [opse_pkg::PROD_W-1:0]         rnd_add;
  logic [opse_pkg::PROD_W-1:0]         rnd_sum;
  logic [opse_pkg::Q_W-1:0]            q_sel;
  logic [opse_pkg::RES_W-1:0]          q_ext;

  assign a_mag = req.a[opse_pkg::A_W-1] ? (opse_pkg::A_W'(0) - req.a) : req.a;
  assign b_mag = req.b[opse_pkg::B_W-1] ? (opse_pkg::B_W'(0) - req.b) : req.b;

  assign chunk = (state_r == M_HI) ? mag_b_r[opse_pkg::B_W-1:opse_pkg::CHUNK_W]
                                   : mag_b_r[opse_pkg::CHUNK_W-1:0];
  assign pp    = mag_a_r * chunk;

  always_comb begin
    case (shift_r)
      opse_pkg::SH_29: rnd_add = opse_pkg::PROD_W'(1) << 28;
      opse_pkg::SH_30: rnd_add = opse_pkg::PROD_W'(1) << 29;
      opse_pkg::SH_32: rnd_add = opse_pkg::PROD_W'(1) << 31;
      default:         rnd_add = '0;
    endcase
  end

  assign rnd_sum = prod_r + rnd_add;

  always_comb begin
    case (shift_r)
      opse_pkg::SH_29: q_sel = rnd_sum[29+opse_pkg::Q_W-1:29];
      opse_pkg::SH_30: q_sel = rnd_sum[30+opse_pkg::Q_W-1:30];
      opse_pkg::SH_32: q_sel = rnd_sum[32+opse_pkg::Q_W-1:32];
      default:         q_sel = rnd_sum[opse_pkg::Q_W-1:0];
    endcase
  end

  assign q_ext = {1'b0, q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      res_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (req.start) begin
            state_r <= M_LO;
          end
        end
        M_LO:  state_r <= M_HI;
        M_HI:  state_r <= M_RND;
        M_RND: state_r <= M_SGN;
        M_SGN: begin
          res_r   <= neg_r ? (opse_pkg::RES_W'(0) - q_ext) : q_ext;
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      M_IDLE: begin
        if (req.start) begin
          mag_a_r <= a_mag;
          mag_b_r <= b_mag;
          neg_r   <= req.a[opse_pkg::A_W-1] ^ req.b[opse_pkg::B_W-1];
          shift_r <= req.shift;
        end
      end
      M_LO:  prod_r <= opse_pkg::PROD_W'(pp);
      M_HI:  prod_r <= prod_r + (opse_pkg::PROD_W'(pp) << opse_pkg::CHUNK_W);
      M_RND: q_r    <= q_sel;
      default: begin
      end
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.busy = (state_r != M_IDLE);
  assign rsp.res  = res_r;

endmodule

[rtl/opse_recip.sv]
// Restoring divider for the Legendre reciprocal floor((2^32 + floor(l/2)) / l).
module opse_recip #(
  parameter int LW = opse_pkg::LW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [LW-1:0]                 l,
  output logic                          done,
  output logic [opse_pkg::RECIP_W-1:0]  recip
);

  localparam int DVD_W = opse_pkg::RECIP_W + 1;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [LW-1:0]                 l_r;
  logic [DVD_W-1:0]              dvd_r;
  logic [LW-1:0]                 rem_r;
  logic [opse_pkg::RECIP_W-1:0]  q_r;

  logic [LW:0]                   trial;
  logic [LW:0]                   diff;
  logic                          ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, l_r};
  assign ge    = (trial >= {1'b0, l_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      l_r   <= l;
      dvd_r <= {1'b1, opse_pkg::RECIP_W'(l >> 1)};
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? diff[LW-1:0] : trial[LW-1:0];
      q_r   <= {q_r[opse_pkg::RECIP_W-2:0], ge};
    end
  end

  assign done  = done_r;
  assign recip = q_r;

endmodule

[bench/orthogonal_poly_series_eval_tb.sv]
// Self-checking bench for the Chebyshev / Legendre series evaluator.
module orthogonal_poly_series_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TERMS = opse_pkg::MAX_TERMS_DEF;

  localparam longint ONE_Q30 = longint'(1) << 30;
  localparam longint POLY_HI = (longint'(1) << 33) - 1;
  localparam longint POLY_LO = -(longint'(1) << 33);
  localparam longint ACC_HI  = (longint'(1) << 47) - 1;
  localparam longint ACC_LO  = -(longint'(1) << 47);

  // basis codes as seen on in_basis
  typedef enum logic [2:0] {
    BAS_CHEB      = 3'd0,
    BAS_CHEB_EVEN = 3'd1,
    BAS_CHEB_ODD  = 3'd2,
    BAS_LEG       = 3'd3,
    BAS_LEG_EVEN  = 3'd4,
    BAS_LEG_ODD   = 3'd5,
    BAS_RSVD6     = 3'd6,
    BAS_RSVD7     = 3'd7
  } basis_e;

  typedef struct {
    logic signed [47:0] sum;
    logic               sat;
  } series_sum_t;

  typedef struct {
    logic signed [31:0] coef;
    logic signed [31:0] point;
    basis_e             basis;
    logic               first;
    logic               last;
    bit                 typed;
    logic signed [47:0] sum;
  } coef_row_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_coefficient = '0;
  logic signed [31:0] in_point       = '0;
  logic [2:0]         in_basis       = '0;
  logic               in_first       = 1'b0;
  logic               in_last        = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic signed [47:0] out_sum;
  logic               out_saturated;

  // typed-in expectation riding along with the request on the wire
  bit                 cur_typed   = 1'b0;
  logic signed [47:0] cur_sum     = '0;

  bit  in_take, out_take;
  bit  calm     = 1'b0;   // no sender gaps for the current series
  logic hold_off = 1'b0;  // long receiver hold-off, driven by its own process
  int  sums_taken = 0;
  int  mismatches = 0;

  series_sum_t pending_sums[$];
  coef_row_t   directed_rows[$];

  // Series evaluator state, mirrored from the block's spec.
  logic signed [33:0] poly_last   = '0;
  logic signed [33:0] poly_older  = '0;
  logic signed [47:0] acc         = '0;
  logic [9:0]         terms_seen  = '0;
  logic signed [31:0] x_held      = '0;
  basis_e             basis_held  = BAS_CHEB;
  logic               sat_seen    = 1'b0;

  orthogonal_poly_series_eval #(.MAX_TERMS(MAX_TERMS)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_coefficient (in_coefficient),
    .in_point       (in_point),
    .in_basis       (in_basis),
    .in_first       (in_first),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sum        (out_sum),
    .out_saturated  (out_saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Arithmetic helpers
  // ------------------------------------------------------------------

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // a*b >> sh, round half away from zero, magnitude capped at 2^62
  function automatic longint mul_round(longint a, longint b, int unsigned sh);
    logic [127:0] mag;
    logic [63:0]  ua, ub;
    bit           flip;
    flip = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    mag  = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (sh - 1))) >> sh;
    if (mag > (128'd1 << 62)) mag = 128'd1 << 62;
    return flip ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  // One step of the three-term recurrence, producing degree l.
  function automatic void next_poly(bit leg, int unsigned l);
    longint p, a, n, recip;
    if (leg) begin
      // Legendre: ((2l-1) x P1 - (l-1) P2) / l, division by reciprocal
      a     = mul_round(x_held, poly_last, 30);
      n     = longint'(2 * l - 1) * a - longint'(l - 1) * longint'(poly_older);
      recip = longint'(((64'd1 << 32) + l / 2) / l);
      p     = mul_round(n, recip, 32);
    end else begin
      p = mul_round(x_held, poly_last, 29) - longint'(poly_older);
    end
    poly_older = poly_last;
    poly_last  = clip(p, POLY_LO, POLY_HI);
  endfunction

  function automatic void restart_series();
    acc        = '0;
    sat_seen   = 1'b0;
    terms_seen = '0;
    poly_older = ONE_Q30;
    poly_last  = x_held;
  endfunction

  // Folds one coefficient into the running sum; returns 1 when a sum is due.
  function automatic bit take_coefficient(input logic signed [31:0] coef,
                                          input logic signed [31:0] point,
                                          input logic [2:0] basis,
                                          input logic first, input logic last,
                                          output series_sum_t res);
    longint      p, s;
    int unsigned k;
    bit          leg, used;
    res.sum = '0;
    res.sat = 1'b0;
    if (first) begin
      x_held     = point;
      basis_held = basis_e'(basis);
      restart_series();
    end
    k    = terms_seen;
    leg  = (basis_held == BAS_LEG) || (basis_held == BAS_LEG_EVEN) ||
           (basis_held == BAS_LEG_ODD);
    used = 1'b1;
    p    = 0;
    // past MAX_TERMS the recurrence freezes and nothing is added
    if (terms_seen < MAX_TERMS) begin
      case (basis_held)
        BAS_CHEB, BAS_LEG: begin
          if (k == 0) p = ONE_Q30;
          else if (k == 1) p = x_held;
          else begin
            next_poly(leg, k);
            p = poly_last;
          end
        end
        BAS_CHEB_EVEN, BAS_LEG_EVEN: begin
          if (k == 0) p = ONE_Q30;
          else begin
            next_poly(leg, 2 * k);
            p = poly_last;
            next_poly(leg, 2 * k + 1);
          end
        end
        BAS_CHEB_ODD, BAS_LEG_ODD: begin
          if (k == 0) p = x_held;
          else begin
            next_poly(leg, 2 * k);
            next_poly(leg, 2 * k + 1);
            p = poly_last;
          end
        end
        default: used = 1'b0;  // reserved codes contribute nothing
      endcase
      if (used) begin
        s = longint'(acc) + mul_round(coef, p, 30);
        if (s > ACC_HI || s < ACC_LO) sat_seen = 1'b1;
        acc = clip(s, ACC_LO, ACC_HI);
      end
      terms_seen = terms_seen + 1;
    end
    if (!last) return 1'b0;
    res.sum = acc;
    res.sat = sat_seen;
    restart_series();
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------
  // Random picks
  // ------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic signed [31:0] pick_point();
    case ($urandom_range(19))
      0:       return 32'sh4000_0000;   // +1.0
      1:       return 32'shC000_0000;   // -1.0
      2:       return '0;
      3, 4:    return $urandom;          // anywhere, about half out of range
      default: return 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_coef();
    case ($urandom_range(19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_basis();
    if ($urandom_range(99) < 4) return $urandom_range(6, 7);
    return $urandom_range(5);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 90) return $urandom_range(1, 10);
    if (r < 97) return $urandom_range(11, 40);
    return $urandom_range(250, 270);  // may run past MAX_TERMS
  endfunction

  // ------------------------------------------------------------------
  // Request driver and checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Offer one coefficient request; returns at the edge that takes it.
  task automatic offer(input logic signed [31:0] coef, input logic signed [31:0] point,
                       input logic [2:0] basis, input logic first, input logic last,
                       input bit typed = 1'b0, input logic signed [47:0] sum = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_coefficient <= coef;
    in_point       <= point;
    in_basis       <= basis;
    in_first       <= first;
    in_last        <= last;
    cur_typed      <= typed;
    cur_sum        <= sum;
    do @(posedge clk); while (!in_take);
  endtask

  task automatic add_row(input logic signed [31:0] coef, input logic signed [31:0] point,
                         input basis_e basis, input logic first, input logic last,
                         input bit typed = 1'b0, input logic signed [47:0] sum = '0);
    coef_row_t row;
    row.coef  = coef;
    row.point = point;
    row.basis = basis;
    row.first = first;
    row.last  = last;
    row.typed = typed;
    row.sum   = sum;
    directed_rows.push_back(row);
  endtask

  // Everything only changes at the rising edge, so the falling edge sees the
  // values that the next rising edge will act on: handshakes are decided here.
  always @(negedge clk) begin
    series_sum_t got, want;
    in_take  = (rst_n === 1'b1) && (in_valid === 1'b1) && (in_stall === 1'b0);
    out_take = (rst_n === 1'b1) && (out_valid === 1'b1) && (out_stall === 1'b0);
    if (in_take && take_coefficient(in_coefficient, in_point, in_basis,
                                    in_first, in_last, got)) begin
      // a typed-in row overrides the computed value (saturation never typed)
      if (cur_typed) begin
        got.sum = cur_sum;
        got.sat = 1'b0;
      end
      pending_sums.push_back(got);
    end
    if (out_take) begin
      sums_taken++;
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result sum=%0d", out_sum));
      end else begin
        want = pending_sums.pop_front();
        if (out_sum !== want.sum)
          report_mismatch($sformatf("sum %0d, expected %0d", out_sum, want.sum));
        if (out_saturated !== want.sat)
          report_mismatch($sformatf("saturated %b, expected %b",
                                    out_saturated, want.sat));
      end
    end
  end

  // ------------------------------------------------------------------
  // Result side: random stall, plus one long hold-off
  // ------------------------------------------------------------------

  initial begin
    int  run, pick;
    bit  level;
    run   = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          level = 1'b0;
          run   = $urandom_range(1, 8);
        end else if (pick < 60) begin
          level = 1'b0;                    // steady stretch, no random stall
          run   = $urandom_range(30, 120);
        end else if (pick < 92) begin
          level = 1'b1;
          run   = $urandom_range(1, 4);
        end else begin
          level = 1'b1;
          run   = $urandom_range(10, 60);
        end
      end
      run--;
      out_stall <= hold_off | level;
    end
  end

  // Once the random part is under way, sit on the result channel long enough
  // that a result parks in the output register and the next last request
  // backs up into the input.
  initial begin
    do @(posedge clk); while (sums_taken < 20);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  initial begin
    int n_items, series, len;
    logic signed [31:0] pt;
    logic [2:0]         bs;
    logic               fst, lst;

    // Directed table. Typed-in sums: degree 0 term equals the coefficient,
    // reserved bases sum to zero, and at x = 1.0 every Chebyshev term is 1.0.
    //       coef              point             basis          first last typed sum
    add_row(32'sd123456,      32'sh0000_0000,   BAS_CHEB,      0, 1, 1, 48'sd123456);
    add_row(32'sh8000_0000,   32'sh4000_0000,   BAS_CHEB,      1, 1, 1, -48'sd2147483648);
    add_row(32'sh7FFF_FFFF,   32'shC000_0000,   BAS_LEG,       1, 1, 1, 48'sd2147483647);
    add_row(32'sh7FFF_FFFF,   32'sh1234_5678,   BAS_RSVD6,     1, 0);
    add_row(32'sh7FFF_FFFF,   32'sh0000_0000,   BAS_CHEB,      0, 1, 1, 48'sd0);
    add_row(32'sh8000_0000,   32'sh4000_0000,   BAS_RSVD7,     1, 1, 1, 48'sd0);
    add_row(32'sh0100_0000,   32'sh4000_0000,   BAS_CHEB,      1, 0);
    add_row(32'sh0100_0000,   32'sh0000_0000,   BAS_CHEB,      0, 0);
    add_row(32'sh0100_0000,   32'sh0000_0000,   BAS_CHEB,      0, 1, 1, 48'sd50331648);
    // no first: picks up the latched point and basis of the last series
    add_row(32'sh0500_0000,   32'sh7777_7777,   BAS_LEG_ODD,   0, 0);
    add_row(32'shFF00_0000,   32'sh0000_0000,   BAS_RSVD7,     0, 1);
    add_row(32'sh0300_0000,   32'shC000_0000,   BAS_CHEB_ODD,  1, 0);
    add_row(32'sh7FFF_FFFF,   32'sh0000_0000,   BAS_CHEB,      0, 1);
    add_row(32'sh0100_0000,   32'sh0000_0000,   BAS_CHEB_EVEN, 1, 0);
    add_row(32'sh8000_0000,   32'sh0000_0000,   BAS_CHEB,      0, 1);
    // x = -2: polynomials clip at the 34-bit limits
    add_row(32'sh0100_0000,   32'sh8000_0000,   BAS_CHEB_ODD,  1, 0);
    add_row(32'sh0100_0000,   32'sh0000_0000,   BAS_CHEB,      0, 0);
    add_row(32'sh7FFF_FFFF,   32'sh0000_0000,   BAS_CHEB,      0, 1);
    add_row(32'sh0200_0000,   32'sh2000_0000,   BAS_LEG,       1, 0);
    add_row(32'shFE00_0000,   32'sh0000_0000,   BAS_CHEB,      0, 0);
    add_row(32'sh0300_0000,   32'sh0000_0000,   BAS_CHEB,      0, 1);
    add_row(32'sh0100_0000,   32'shC000_0000,   BAS_LEG_EVEN,  1, 0);
    add_row(32'sh8000_0000,   32'sh0000_0000,   BAS_CHEB,      0, 1);
    add_row(32'sh0100_0000,   32'sh4000_0000,   BAS_LEG_ODD,   1, 0);
    add_row(32'sh7FFF_FFFF,   32'sh0000_0000,   BAS_CHEB,      0, 1);
    // first again mid-series: the series restarts on the new point
    add_row(32'sh0100_0000,   32'sh2000_0000,   BAS_CHEB,      1, 0);
    add_row(32'sh0400_0000,   32'sh1000_0000,   BAS_LEG_ODD,   1, 1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer(directed_rows[i].coef, directed_rows[i].point, directed_rows[i].basis,
            directed_rows[i].first, directed_rows[i].last,
            directed_rows[i].typed, directed_rows[i].sum);

    // Random series: mostly well formed, with a missing first, a stray first
    // or a dropped last now and then. The opening series overruns MAX_TERMS.
    n_items = 0;
    series  = 0;
    while (n_items < 1000) begin
      len  = (series == 0) ? 262 : pick_len();
      calm = ($urandom_range(4) == 0);
      for (int i = 0; i < len; i++) begin
        if (i == 0) fst = ($urandom_range(99) >= 6);
        else        fst = ($urandom_range(99) < 2);
        lst = (i == len - 1) ? ($urandom_range(99) >= 3) : 1'b0;
        // point and basis only matter on a first request; random otherwise
        pt = fst ? pick_point() : 32'($urandom);
        bs = fst ? pick_basis() : 3'($urandom_range(7));
        offer(pick_coef(), pt, bs, fst, lst);
        n_items++;
      end
      series++;
    end
    in_valid <= 1'b0;

    // drain, then give a slow Legendre step time to show any stray result
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
